[rtl/int8_matmul_dequantize_unit_macros.svh]
// Assertion macros shared by the checker.
`ifndef INT8_MATMUL_DEQUANTIZE_UNIT_MACROS_SVH
`define INT8_MATMUL_DEQUANTIZE_UNIT_MACROS_SVH

// Checked outside reset.
`define IMD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("imd assertion failed");

// Checked through reset as well.
`define IMD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("imd reset assertion failed");

`endif

[rtl/imd_pkg.sv]
package imd_pkg;

  localparam int DIM_W    = 13;
  localparam int IDX_W    = 12;
  localparam int SUM_W    = 28;
  localparam int SCALE_W  = 32;
  localparam int PROD_W   = SUM_W + SCALE_W;
  localparam int SCALED_W = 59;

  localparam int MAX_ROWS  = 4096;
  localparam int MAX_COLS  = 4096;
  localparam int MAX_INNER = 4096;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_ROW_COUNT      = 2'd0,
    CFG_COL_COUNT      = 2'd1,
    CFG_INNER_LENGTH   = 2'd2,
    CFG_COMBINED_SCALE = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]   row_count;
    logic [DIM_W-1:0]   col_count;
    logic [DIM_W-1:0]   inner_length;
    logic [SCALE_W-1:0] combined_scale;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    done;
  } entry_t;

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/imd_fifo.sv]
module imd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  imd_pkg::entry_t push_entry,
  input  logic            pop,
  output imd_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  imd_pkg::entry_t                 mem [imd_pkg::FIFO_DEPTH];
  logic [imd_pkg::PTR_W-1:0]       wr_ptr;
  logic [imd_pkg::PTR_W-1:0]       rd_ptr;
  logic [imd_pkg::CNT_W-1:0]       count;

  assign full  = (count == imd_pkg::CNT_W'(imd_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + imd_pkg::PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + imd_pkg::PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + imd_pkg::CNT_W'(1);
        2'b01:   count <= count - imd_pkg::CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/imd_front.sv]
module imd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] left_value,
  input  logic signed [7:0] right_value,
  input  imd_pkg::cfg_t     cfg,
  input  logic              full,
  output logic              push,
  output imd_pkg::entry_t   push_entry
);

  logic signed [imd_pkg::SUM_W-1:0] running_sum;
  logic [imd_pkg::IDX_W-1:0]        inner_index;
  logic [imd_pkg::IDX_W-1:0]        col_index;
  logic [imd_pkg::IDX_W-1:0]        row_index;

  logic signed [15:0]               prod;
  logic signed [imd_pkg::SUM_W-1:0] sum_next;
  logic [imd_pkg::DIM_W-1:0]        rows;
  logic [imd_pkg::DIM_W-1:0]        cols;
  logic [imd_pkg::DIM_W-1:0]        inner;
  logic                             inner_end;
  logic                             col_end;
  logic                             row_end;
  logic                             accept;

  assign rows  = imd_pkg::eff_dim(cfg.row_count, imd_pkg::DIM_W'(imd_pkg::MAX_ROWS));
  assign cols  = imd_pkg::eff_dim(cfg.col_count, imd_pkg::DIM_W'(imd_pkg::MAX_COLS));
  assign inner = imd_pkg::eff_dim(cfg.inner_length, imd_pkg::DIM_W'(imd_pkg::MAX_INNER));

  assign prod     = left_value * right_value;
  assign sum_next = running_sum + {{(imd_pkg::SUM_W-16){prod[15]}}, prod};

  assign inner_end = {1'b0, inner_index} >= inner - imd_pkg::DIM_W'(1);
  assign col_end   = {1'b0, col_index} >= cols - imd_pkg::DIM_W'(1);
  assign row_end   = {1'b0, row_index} >= rows - imd_pkg::DIM_W'(1);

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && inner_end;

  always_comb begin
    push_entry.row  = row_index;
    push_entry.col  = col_index;
    push_entry.sum  = sum_next;
    push_entry.done = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      inner_index <= '0;
      col_index   <= '0;
      row_index   <= '0;
    end else if (accept) begin
      if (!inner_end) begin
        running_sum <= sum_next;
        inner_index <= inner_index + imd_pkg::IDX_W'(1);
      end else begin
        running_sum <= '0;
        inner_index <= '0;
        if (col_end) begin
          col_index <= '0;
          if (row_end) begin
            row_index <= '0;
          end else begin
            row_index <= row_index + imd_pkg::IDX_W'(1);
          end
        end else begin
          col_index <= col_index + imd_pkg::IDX_W'(1);
        end
      end
    end
  end

endmodule

[rtl/imd_back.sv]
module imd_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  empty,
  input  imd_pkg::entry_t                       head,
  output logic                                  pop,
  input  logic [imd_pkg::SCALE_W-1:0]           combined_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [imd_pkg::IDX_W-1:0]             out_row,
  output logic [imd_pkg::IDX_W-1:0]             out_col,
  output logic signed [imd_pkg::SUM_W-1:0]      raw_sum,
  output logic signed [imd_pkg::SCALED_W-1:0]   scaled_value,
  output logic                                  matrix_done
);

  localparam logic [imd_pkg::PROD_W-1:0] MINMAG = imd_pkg::PROD_W'(1) << (imd_pkg::SCALED_W-1);
  localparam logic [imd_pkg::PROD_W-1:0] MAXMAG = MINMAG - imd_pkg::PROD_W'(1);

  logic                          advance;
  logic                          a_valid;
  logic                          b_valid;
  logic                          a_neg;
  logic                          b_neg;
  logic [imd_pkg::SUM_W-1:0]     a_mag;
  logic [imd_pkg::PROD_W-1:0]    b_prod;
  imd_pkg::entry_t               a_meta;
  imd_pkg::entry_t               b_meta;
  logic [imd_pkg::PROD_W-1:0]    sat;
  logic [imd_pkg::SCALED_W-1:0]  scaled_next;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;

  always_comb begin
    if (b_neg) begin
      sat         = (b_prod > MINMAG) ? MINMAG : b_prod;
      scaled_next = imd_pkg::SCALED_W'(-sat);
    end else begin
      sat         = (b_prod > MAXMAG) ? MAXMAG : b_prod;
      scaled_next = sat[imd_pkg::SCALED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= !empty;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_meta <= head;
      a_neg  <= head.sum[imd_pkg::SUM_W-1];
      a_mag  <= head.sum[imd_pkg::SUM_W-1] ? imd_pkg::SUM_W'(-head.sum) : head.sum;
      b_meta <= a_meta;
      b_neg  <= a_neg;
      b_prod <= {{imd_pkg::SCALE_W{1'b0}}, a_mag} * {{imd_pkg::SUM_W{1'b0}}, combined_scale};
      out_row      <= b_meta.row;
      out_col      <= b_meta.col;
      raw_sum      <= b_meta.sum;
      matrix_done  <= b_meta.done;
      scaled_value <= scaled_next;
    end
  end

endmodule

[rtl/int8_matmul_dequantize_unit.sv]
// int8 matrix multiply with Q8.24 dequantize scale.
// Input channel (in_valid/in_stall): one left_value/right_value pair per transfer,
// in row, column, inner order. One multiply-accumulate per cycle; a pair is taken
// every cycle while the four-entry result queue has room.
// After inner_length pairs one result leaves on the output channel (out_valid/
// out_stall): row, column, raw dot product, product times combined_scale, and
// matrix_done on the last element of the matrix.
// After the transfer of the last pair of a dot product the result passes the queue
// (written at the transfer edge), then the magnitude stage, the 28x32 multiply stage
// and the saturate/output register before out_valid.
// The back end can deliver one result per cycle while out_stall stays low.
// When out_stall is high with out_valid high, the output register holds, the back
// pipeline freezes, the queue fills and then in_stall rises.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write only
// while idle. Reset clears counters, accumulator, queue and pipeline, and loads
// dimensions of 1 and a scale of 1.0.
module int8_matmul_dequantize_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [7:0]                   left_value,
  input  logic signed [7:0]                   right_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [imd_pkg::IDX_W-1:0]           out_row,
  output logic [imd_pkg::IDX_W-1:0]           out_col,
  output logic signed [imd_pkg::SUM_W-1:0]    raw_sum,
  output logic signed [imd_pkg::SCALED_W-1:0] scaled_value,
  output logic                                matrix_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  imd_pkg::cfg_index_t                 cfg_index,
  input  logic [imd_pkg::SCALE_W-1:0]         cfg_data
);

  imd_pkg::cfg_t   cfg;
  imd_pkg::entry_t push_entry;
  imd_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count      <= imd_pkg::DIM_W'(1);
      cfg.col_count      <= imd_pkg::DIM_W'(1);
      cfg.inner_length   <= imd_pkg::DIM_W'(1);
      cfg.combined_scale <= imd_pkg::SCALE_W'(32'h0100_0000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imd_pkg::CFG_ROW_COUNT:      cfg.row_count      <= cfg_data[imd_pkg::DIM_W-1:0];
        imd_pkg::CFG_COL_COUNT:      cfg.col_count      <= cfg_data[imd_pkg::DIM_W-1:0];
        imd_pkg::CFG_INNER_LENGTH:   cfg.inner_length   <= cfg_data[imd_pkg::DIM_W-1:0];
        imd_pkg::CFG_COMBINED_SCALE: cfg.combined_scale <= cfg_data;
        default:                     cfg                <= cfg;
      endcase
    end
  end

  imd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_value  (left_value),
    .right_value (right_value),
    .cfg         (cfg),
    .full        (full),
    .push        (push),
    .push_entry  (push_entry)
  );

  imd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  imd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .combined_scale (cfg.combined_scale),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .raw_sum        (raw_sum),
    .scaled_value   (scaled_value),
    .matrix_done    (matrix_done)
  );

endmodule

[rtl/imd_checker.sv]
`include "int8_matmul_dequantize_unit_macros.svh"

module imd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [imd_pkg::IDX_W-1:0]           out_row,
  input logic [imd_pkg::IDX_W-1:0]           out_col,
  input logic signed [imd_pkg::SUM_W-1:0]    raw_sum,
  input logic signed [imd_pkg::SCALED_W-1:0] scaled_value,
  input logic                                matrix_done
);

  logic [2*imd_pkg::IDX_W+imd_pkg::SUM_W+imd_pkg::SCALED_W:0] out_bits;

  assign out_bits = {out_row, out_col, raw_sum, scaled_value, matrix_done};

  `IMD_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid)
  `IMD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_bits))
  `IMD_ASSERT(a_zero_sum_zero_scaled, out_valid && raw_sum == '0 |-> scaled_value == '0)
  `IMD_ASSERT(a_sign_kept, out_valid && raw_sum >= 0 |-> scaled_value >= 0)

endmodule

bind int8_matmul_dequantize_unit imd_checker u_imd_checker (.*);
